/* rtl/cpd_pkg.sv */
// cpd_pkg: shared types and constants for the configuration packet deframer
// holds the word kind codes, header field positions and the result struct
// no dependencies
`timescale 1ns / 1ps

package cpd_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned AddrW   = 14;
  localparam int unsigned CountW  = 27;
  localparam int unsigned OpW     = 2;
  localparam int unsigned TypeW   = 3;
  localparam int unsigned Cnt1W   = 11;

  // header field positions
  localparam int unsigned TypeHi  = 31;
  localparam int unsigned TypeLo  = 29;
  localparam int unsigned OpHi    = 28;
  localparam int unsigned OpLo    = 27;
  localparam int unsigned AddrHi  = 26;
  localparam int unsigned AddrLo  = 13;
  localparam int unsigned Cnt1Hi  = 10;
  localparam int unsigned Cnt2Hi  = 26;

  // header type codes
  localparam logic [TypeW-1:0] HDR_TYPE1 = 3'd1;
  localparam logic [TypeW-1:0] HDR_TYPE2 = 3'd2;

  typedef enum logic [2:0] {
    KIND_TYPE1   = 3'd0,
    KIND_TYPE2   = 3'd1,
    KIND_PAYLOAD = 3'd2,
    KIND_BAD     = 3'd3,
    KIND_DISCARD = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t              word_kind;
    logic               packet_valid;
    logic [OpW-1:0]     packet_opcode;
    logic [AddrW-1:0]   register_address;
    logic [CountW-1:0]  payload_count;
    logic [WordW-1:0]   word_value;
    logic               packet_last;
  } res_t;

endpackage

/* rtl/cpd_if.sv */
// cpd_word_if and cpd_result_if: valid/ready channels of the deframer
// the word channel carries one bitstream word, the result channel one tagged word
// depends on cpd_pkg
`timescale 1ns / 1ps

interface cpd_word_if import cpd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WordW-1:0] stream_word;

  modport source (output valid, output stream_word, input ready);
  modport sink   (input valid, input stream_word, output ready);
endinterface

interface cpd_result_if import cpd_pkg::*; ();
  logic              valid;
  logic              ready;
  kind_t             word_kind;
  logic              packet_valid;
  logic [OpW-1:0]    packet_opcode;
  logic [AddrW-1:0]  register_address;
  logic [CountW-1:0] payload_count;
  logic [WordW-1:0]  word_value;
  logic              packet_last;

  modport source (output valid, output word_kind, output packet_valid,
                  output packet_opcode, output register_address,
                  output payload_count, output word_value, output packet_last,
                  input ready);
  modport sink   (input valid, input word_kind, input packet_valid,
                  input packet_opcode, input register_address,
                  input payload_count, input word_value, input packet_last,
                  output ready);
endinterface

/* rtl/cpd_parse.sv */
// cpd_parse: packet parse state and the per-word tagging logic
// state advances on step; result is combinational from the registered word
// depends on cpd_pkg
`timescale 1ns / 1ps

module cpd_parse import cpd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [WordW-1:0] word,
  output res_t             res
);

  logic [CountW-1:0] remaining_r, remaining_nxt;
  logic [OpW-1:0]    opcode_r, opcode_nxt;
  logic [AddrW-1:0]  address_r, address_nxt;
  logic              valid_r, valid_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic              have_prev_r, have_prev_nxt;
  logic [AddrW-1:0]  prev_addr_r, prev_addr_nxt;
  logic              stopped_r, stopped_nxt;

  logic [TypeW-1:0]  hdr_type;
  logic [OpW-1:0]    hdr_op;
  logic [AddrW-1:0]  hdr_addr;
  logic [CountW-1:0] cnt1;
  logic [CountW-1:0] cnt2;

  // header field extraction
  assign hdr_type = word[TypeHi:TypeLo];
  assign hdr_op   = word[OpHi:OpLo];
  assign hdr_addr = word[AddrHi:AddrLo];
  assign cnt1     = {{(CountW-Cnt1W){1'b0}}, word[Cnt1Hi:0]};
  assign cnt2     = word[Cnt2Hi:0];

  // tagging and next state
  always_comb begin
    remaining_nxt = remaining_r;
    opcode_nxt    = opcode_r;
    address_nxt   = address_r;
    valid_nxt     = valid_r;
    count_nxt     = count_r;
    have_prev_nxt = have_prev_r;
    prev_addr_nxt = prev_addr_r;
    stopped_nxt   = stopped_r;
    res            = '0;
    res.word_kind  = KIND_DISCARD;
    res.word_value = word;
    priority if (stopped_r) begin
      res.word_kind = KIND_DISCARD;
    end else if (remaining_r != '0) begin
      res.word_kind        = KIND_PAYLOAD;
      res.packet_valid     = valid_r;
      res.packet_opcode    = opcode_r;
      res.register_address = address_r;
      res.payload_count    = count_r;
      res.packet_last      = (remaining_r == CountW'(1));
      remaining_nxt        = remaining_r - CountW'(1);
    end else begin
      unique case (hdr_type)
        HDR_TYPE1: begin
          opcode_nxt    = hdr_op;
          address_nxt   = hdr_addr;
          count_nxt     = cnt1;
          valid_nxt     = 1'b1;
          have_prev_nxt = 1'b1;
          prev_addr_nxt = hdr_addr;
          remaining_nxt = cnt1;
          res.word_kind        = KIND_TYPE1;
          res.packet_valid     = 1'b1;
          res.packet_opcode    = hdr_op;
          res.register_address = hdr_addr;
          res.payload_count    = cnt1;
          res.packet_last      = (cnt1 == '0);
        end
        HDR_TYPE2: begin
          opcode_nxt    = hdr_op;
          count_nxt     = cnt2;
          valid_nxt     = have_prev_r;
          address_nxt   = have_prev_r ? prev_addr_r : '0;
          remaining_nxt = cnt2;
          res.word_kind        = KIND_TYPE2;
          res.packet_valid     = have_prev_r;
          res.packet_opcode    = hdr_op;
          res.register_address = have_prev_r ? prev_addr_r : '0;
          res.payload_count    = cnt2;
          res.packet_last      = (cnt2 == '0);
        end
        default: begin
          stopped_nxt   = 1'b1;
          res.word_kind = KIND_BAD;
        end
      endcase
    end
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remaining_r <= '0;
      opcode_r    <= '0;
      address_r   <= '0;
      valid_r     <= 1'b0;
      count_r     <= '0;
      have_prev_r <= 1'b0;
      prev_addr_r <= '0;
      stopped_r   <= 1'b0;
    end else if (step) begin
      remaining_r <= remaining_nxt;
      opcode_r    <= opcode_nxt;
      address_r   <= address_nxt;
      valid_r     <= valid_nxt;
      count_r     <= count_nxt;
      have_prev_r <= have_prev_nxt;
      prev_addr_r <= prev_addr_nxt;
      stopped_r   <= stopped_nxt;
    end
  end

endmodule

/* rtl/config_packet_deframer.sv */
// config_packet_deframer: splits a configuration bitstream into tagged packet words
// path: an input transaction passes the input register, then the result register, before result valid
// throughput: one word per cycle while out_chan.ready allows; both stages advance whenever the result register frees up
// reset: synchronous active-low rst_n clears both stage valids and the parse state,
// so the next word is taken as a header and no earlier packet is known
`timescale 1ns / 1ps

module config_packet_deframer import cpd_pkg::*; (
  input logic          clk,
  input logic          rst_n,
  cpd_word_if.sink     in_chan,
  cpd_result_if.source out_chan
);

  logic             s1_valid_r;
  logic [WordW-1:0] s1_word_r;
  logic             out_valid_r;
  res_t             out_r;
  res_t             res;
  logic             out_free;
  logic             s1_advance;
  logic             in_fire;

  // pipeline control
  assign out_free   = !out_valid_r || out_chan.ready;
  assign s1_advance = s1_valid_r && out_free;
  assign in_chan.ready = !s1_valid_r || out_free;
  assign in_fire    = in_chan.valid && in_chan.ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_word_r <= in_chan.stream_word;
    end
  end

  cpd_parse u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s1_advance),
    .word  (s1_word_r),
    .res   (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_r <= res;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.word_kind        = out_r.word_kind;
  assign out_chan.packet_valid     = out_r.packet_valid;
  assign out_chan.packet_opcode    = out_r.packet_opcode;
  assign out_chan.register_address = out_r.register_address;
  assign out_chan.payload_count    = out_r.payload_count;
  assign out_chan.word_value       = out_r.word_value;
  assign out_chan.packet_last      = out_r.packet_last;

  // payload words only come from packets with a nonzero count
  a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.word_kind == KIND_PAYLOAD) |-> (out_r.payload_count != '0))
    else $error("payload word tagged with zero count");

  // a type-1 header always delivers its packet
  a_type1_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.word_kind == KIND_TYPE1) |-> out_r.packet_valid)
    else $error("type-1 header not marked valid");

  // after a bad header only discarded words follow
  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_chan.ready && out_r.word_kind == KIND_BAD) |=>
    !(out_valid_r && (out_r.word_kind == KIND_TYPE1 || out_r.word_kind == KIND_TYPE2 ||
                      out_r.word_kind == KIND_PAYLOAD || out_r.word_kind == KIND_BAD)))
    else $error("parse resumed after bad header");

  // an accepted word is held in the input stage
  a_in_capture: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r)
    else $error("accepted word lost from input stage");

endmodule
